// ----- rtl/rfid_hex_pkg.sv -----
// ----------------------------------------------------------------------------
// rfid_hex_pkg
// Shared types and constants for the ASCII hex tag frame decoder.
// ----------------------------------------------------------------------------
package rfid_hex_pkg;

  // Frame geometry
  localparam int unsigned DATA_BYTES  = 5;
  localparam int unsigned FRAME_CHARS = 2 * (DATA_BYTES + 1);
  localparam int unsigned TAG_BITS    = 40;

  localparam logic [3:0] LAST_IDX     = 4'(FRAME_CHARS - 1);
  localparam logic [3:0] DATA_BYTES_W = 4'(DATA_BYTES);

  // ASCII bounds of the accepted digits
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [3:0] HEX_A_VAL = 4'd10;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_BAD_CHAR = 2'd2
  } status_t;

  // One classified character, front to back
  typedef struct packed {
    logic [3:0] nib;
    logic       bad;
    logic       start;
  } char_t;

endpackage

// ----- rtl/rfid_hex_tag_decode_check_top.sv -----
// ----------------------------------------------------------------------------
// rfid_hex_tag_decode_check_top
// ASCII hex RFID tag frame decoder with XOR checksum check.
// ----------------------------------------------------------------------------
// Input channel: one ASCII character per transaction (in_ch) plus
// in_frame_start, which restarts the frame with this character. A frame is
// 2*(DATA_BYTES+1) uppercase hex digits; pairs form bytes, the first
// DATA_BYTES bytes are tag data, the final byte is the checksum.
// Output channel: one transaction per complete frame with the tag data
// (first byte most significant), the received checksum and a status
// (ok, checksum mismatch, bad character seen anywhere in the frame).
// Throughput: one character per cycle, sustained while the receiver does
// not stall. The frame engine updates its state once per character.
// The last character of a frame enters the two-entry queue when it is
// accepted; the frame engine loads the result into the output register
// when it takes that character from the queue.
// When the receiver stalls, the output register holds, the queue fills and
// in_stall rises once it is full; no character or result is dropped.
// Reset (synchronous, active low) empties the queue, clears the frame
// state and drops any pending result.
module rfid_hex_tag_decode_check_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_ch,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rfid_hex_pkg::TAG_BITS-1:0]  out_tag_data,
  output logic [7:0]                         out_tag_checksum,
  output logic [1:0]                         out_status
);

  logic                 push;
  rfid_hex_pkg::char_t  push_data;
  logic                 full;
  logic                 head_valid;
  rfid_hex_pkg::char_t  head_data;
  logic                 pop;

  // Character classification
  rfid_hex_front u_front (
    .in_valid       (in_valid),
    .in_ch          (in_ch),
    .in_frame_start (in_frame_start),
    .push           (push),
    .push_data      (push_data)
  );

  // Decoupling queue
  rfid_hex_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  assign in_stall = full;

  // Frame engine and result register
  rfid_hex_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_data        (head_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tag_data     (out_tag_data),
    .out_tag_checksum (out_tag_checksum),
    .out_status       (out_status)
  );

endmodule

// ----- rtl/rfid_hex_front.sv -----
// ----------------------------------------------------------------------------
// rfid_hex_front
// Classifies one incoming character: hex digit value, bad flag, frame start.
// ----------------------------------------------------------------------------
module rfid_hex_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_ch,
  input  logic                 in_frame_start,
  output logic                 push,
  output rfid_hex_pkg::char_t  push_data
);

  logic is_dec;
  logic is_hex;

  // Digit range checks
  assign is_dec = (in_ch >= rfid_hex_pkg::CHAR_0) && (in_ch <= rfid_hex_pkg::CHAR_9);
  assign is_hex = (in_ch >= rfid_hex_pkg::CHAR_A) && (in_ch <= rfid_hex_pkg::CHAR_F);

  // Digit value; a non-digit counts as zero and is flagged
  always_comb begin
    push_data.start = in_frame_start;
    push_data.bad   = !(is_dec || is_hex);
    if (is_dec) begin
      push_data.nib = in_ch[3:0];
    end else if (is_hex) begin
      push_data.nib = 4'(in_ch - rfid_hex_pkg::CHAR_A) + rfid_hex_pkg::HEX_A_VAL;
    end else begin
      push_data.nib = 4'd0;
    end
  end

  assign push = in_valid;

endmodule

// ----- rtl/rfid_hex_queue.sv -----
// ----------------------------------------------------------------------------
// rfid_hex_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module rfid_hex_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rfid_hex_pkg::char_t  push_data,
  output logic                 full,
  output logic                 head_valid,
  output rfid_hex_pkg::char_t  head_data,
  input  logic                 pop
);

  rfid_hex_pkg::char_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/rfid_hex_back.sv -----
// ----------------------------------------------------------------------------
// rfid_hex_back
// Frame engine: packs digits into bytes, XOR-checks, registers the result.
// ----------------------------------------------------------------------------
module rfid_hex_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                head_valid,
  input  rfid_hex_pkg::char_t                 head_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rfid_hex_pkg::TAG_BITS-1:0]   out_tag_data,
  output logic [7:0]                          out_tag_checksum,
  output logic [1:0]                          out_status
);

  // Frame state
  logic [3:0]                        char_index_r, char_index_nxt;
  logic [3:0]                        high_nibble_r, high_nibble_nxt;
  logic [rfid_hex_pkg::TAG_BITS-1:0] data_shift_r, data_shift_nxt;
  logic [7:0]                        xor_accum_r, xor_accum_nxt;
  logic                              bad_r, bad_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic [rfid_hex_pkg::TAG_BITS-1:0] tag_data_r;
  logic [7:0]                        checksum_r;
  rfid_hex_pkg::status_t             status_r, status_nxt;

  // Working values with frame start applied
  logic [3:0]                        idx;
  logic [3:0]                        hi_eff;
  logic [rfid_hex_pkg::TAG_BITS-1:0] shift_eff;
  logic [7:0]                        xor_eff;
  logic                              bad_eff;
  logic [7:0]                        byte_val;
  logic                              emit;

  // Take a character whenever the output register is free or draining
  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    idx       = head_data.start ? 4'd0 : char_index_r;
    hi_eff    = head_data.start ? 4'd0 : high_nibble_r;
    shift_eff = head_data.start ? '0   : data_shift_r;
    xor_eff   = head_data.start ? 8'd0 : xor_accum_r;
    bad_eff   = (head_data.start ? 1'b0 : bad_r) | head_data.bad;
    byte_val  = {hi_eff, head_data.nib};

    char_index_nxt  = char_index_r;
    high_nibble_nxt = high_nibble_r;
    data_shift_nxt  = data_shift_r;
    xor_accum_nxt   = xor_accum_r;
    bad_nxt         = bad_r;
    emit            = 1'b0;

    if (pop) begin
      char_index_nxt  = idx + 4'd1;
      high_nibble_nxt = hi_eff;
      data_shift_nxt  = shift_eff;
      xor_accum_nxt   = xor_eff;
      bad_nxt         = bad_eff;
      if (!idx[0]) begin
        // first digit of a byte
        high_nibble_nxt = head_data.nib;
      end else begin
        // second digit: data byte or checksum
        if ({1'b0, idx[3:1]} < rfid_hex_pkg::DATA_BYTES_W) begin
          data_shift_nxt = {shift_eff[rfid_hex_pkg::TAG_BITS-9:0], byte_val};
          xor_accum_nxt  = xor_eff ^ byte_val;
        end
        if (idx >= rfid_hex_pkg::LAST_IDX) begin
          emit = 1'b1;
        end
      end
    end
  end

  // Result status
  always_comb begin
    if (bad_eff) begin
      status_nxt = rfid_hex_pkg::STATUS_BAD_CHAR;
    end else if (xor_accum_nxt != byte_val) begin
      status_nxt = rfid_hex_pkg::STATUS_MISMATCH;
    end else begin
      status_nxt = rfid_hex_pkg::STATUS_OK;
    end
  end

  // Output valid: set on a result, cleared once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_index_r  <= 4'd0;
      high_nibble_r <= 4'd0;
      data_shift_r  <= '0;
      xor_accum_r   <= 8'd0;
      bad_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        char_index_r  <= 4'd0;
        high_nibble_r <= 4'd0;
        data_shift_r  <= '0;
        xor_accum_r   <= 8'd0;
        bad_r         <= 1'b0;
      end else begin
        char_index_r  <= char_index_nxt;
        high_nibble_r <= high_nibble_nxt;
        data_shift_r  <= data_shift_nxt;
        xor_accum_r   <= xor_accum_nxt;
        bad_r         <= bad_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      tag_data_r <= data_shift_nxt;
      checksum_r <= byte_val;
      status_r   <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tag_data     = tag_data_r;
  assign out_tag_checksum = checksum_r;
  assign out_status       = status_r;

endmodule

// ----- dv/rfid_hex_tag_decode_check_top_tb.sv -----
// ----------------------------------------------------------------------------
// rfid_hex_tag_decode_check_top_tb
// Self-checking bench for the ASCII hex tag frame decoder. A short table of
// hand-written frames comes first, then random frames: most are well formed
// with random data, some carry a wrong checksum or a non-hex character, and
// some are noise or cut off by a restart. Each transaction is run through a
// cycle-free frame decoder here, and every result the block emits is checked
// field by field against the oldest expected frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rfid_hex_tag_decode_check_top_tb;
  import rfid_hex_pkg::*;

  localparam int RAND_CHARS = 1900;
  localparam int QUIET_CHARS = 250;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [7:0]          cs;
    status_t             st;
  } tag_result_t;

  typedef struct {
    logic [7:0]  ch;
    logic        start;
    bit          fixed;
    tag_result_t res;
  } dir_row_t;

  typedef enum {FR_GOOD, FR_MISMATCH, FR_BADCHAR, FR_NOISE} frame_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_ch = 8'h00;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TAG_BITS-1:0] out_tag_data;
  logic [7:0] out_tag_checksum;
  logic [1:0] out_status;

  // Frame decoder state mirrored on the bench side
  logic [3:0]          fr_pos;
  logic [3:0]          fr_hi_nib;
  logic [TAG_BITS-1:0] fr_tag;
  logic [7:0]          fr_xsum;
  logic                fr_bad;

  tag_result_t expected_tags[$];
  dir_row_t    dir_rows[$];

  int errors = 0;
  int chars_sent = 0;
  int frames_seen = 0;
  int n_ok = 0;
  int n_mismatch = 0;
  int n_bad = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  rfid_hex_tag_decode_check_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tag_data     (out_tag_data),
    .out_tag_checksum (out_tag_checksum),
    .out_status       (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void clear_frame_state();
    fr_pos    = '0;
    fr_hi_nib = '0;
    fr_tag    = '0;
    fr_xsum   = '0;
    fr_bad    = 1'b0;
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_A && c <= CHAR_F);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < HEX_A_VAL) ? CHAR_0 + 8'(n) : CHAR_A + 8'(n - HEX_A_VAL);
  endfunction

  // Advance the frame decoder by one character; returns 1 on frame end
  function automatic bit decode_char(input logic [7:0] c, input logic s,
                                     output tag_result_t r);
    logic [3:0] nib;
    logic [7:0] byte_val;
    if (s) clear_frame_state();
    r = '0;
    if (c >= CHAR_0 && c <= CHAR_9)
      nib = 4'(c - CHAR_0);
    else if (c >= CHAR_A && c <= CHAR_F)
      nib = 4'(c - CHAR_A) + HEX_A_VAL;
    else begin
      nib = 4'd0;
      fr_bad = 1'b1;
    end
    // even position: high nibble only
    if (!fr_pos[0]) begin
      fr_hi_nib = nib;
      fr_pos = fr_pos + 4'd1;
      return 1'b0;
    end
    byte_val = {fr_hi_nib, nib};
    if ((fr_pos >> 1) < DATA_BYTES_W) begin
      fr_tag  = {fr_tag[TAG_BITS-9:0], byte_val};
      fr_xsum = fr_xsum ^ byte_val;
    end
    if (fr_pos >= LAST_IDX) begin
      r.tag = fr_tag;
      r.cs  = byte_val;
      if (fr_bad)
        r.st = STATUS_BAD_CHAR;
      else if (fr_xsum != byte_val)
        r.st = STATUS_MISMATCH;
      else
        r.st = STATUS_OK;
      clear_frame_state();
      return 1'b1;
    end
    fr_pos = fr_pos + 4'd1;
    return 1'b0;
  endfunction

  // Offer one character and wait for the block to take it
  task automatic send_char(input logic [7:0] c, input logic s, input bit fixed,
                           input tag_result_t fixed_res);
    tag_result_t r;
    if (!quiet && $urandom_range(7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch          <= c;
    in_frame_start <= s;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    chars_sent++;
    if (decode_char(c, s, r))
      expected_tags.push_back(fixed ? fixed_res : r);
  endtask

  task automatic add_row(input logic [7:0] c, input logic s, input bit fixed,
                         input tag_result_t r);
    dir_row_t row;
    row.ch    = c;
    row.start = s;
    row.fixed = fixed;
    row.res   = r;
    dir_rows.push_back(row);
  endtask

  // One random frame of the given kind
  task automatic send_frame(input frame_kind_t kind, input bit need_start);
    logic [7:0] bytes [DATA_BYTES+1];
    logic [7:0] chars [FRAME_CHARS];
    logic [7:0] xs;
    logic [7:0] bc;
    int p;
    xs = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      bytes[i] = 8'($urandom);
      xs ^= bytes[i];
    end
    bytes[DATA_BYTES] = (kind == FR_MISMATCH) ? xs ^ 8'($urandom_range(1, 255)) : xs;
    for (int i = 0; i < FRAME_CHARS; i++)
      chars[i] = hex_char((i % 2) ? bytes[i/2][3:0] : bytes[i/2][7:4]);
    if (kind == FR_BADCHAR) begin
      // characters just outside the digit ranges, lowercase, or anything else
      case ($urandom_range(5))
        0: bc = CHAR_0 - 8'd1;
        1: bc = CHAR_9 + 8'd1;
        2: bc = CHAR_A - 8'd1;
        3: bc = CHAR_F + 8'd1;
        4: bc = "a" + 8'($urandom_range(5));
        default: do bc = 8'($urandom_range(255)); while (is_hex_char(bc));
      endcase
      p = $urandom_range(FRAME_CHARS - 1);
      chars[p] = bc;
    end
    for (int i = 0; i < FRAME_CHARS; i++)
      send_char(chars[i], (i == 0) && (need_start || $urandom_range(1)), 1'b0, '0);
  endtask

  // Noise or a cut-off frame; never long enough to finish one
  task automatic send_noise();
    int n;
    logic [7:0] c;
    n = $urandom_range(1, FRAME_CHARS - 1);
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(1) ? hex_char(4'($urandom)) : 8'($urandom_range(255));
      send_char(c, (i == 0) || ($urandom_range(9) == 0), 1'b0, '0);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    tag_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      frames_seen++;
      case (out_status)
        STATUS_OK:       n_ok++;
        STATUS_MISMATCH: n_mismatch++;
        default:         n_bad++;
      endcase
      if (expected_tags.size() == 0) begin
        note_error($sformatf("unexpected result tag=%h cs=%h st=%0d",
                             out_tag_data, out_tag_checksum, out_status));
      end else begin
        e = expected_tags.pop_front();
        if (out_tag_data !== e.tag)
          note_error($sformatf("tag_data %h, expected %h", out_tag_data, e.tag));
        if (out_tag_checksum !== e.cs)
          note_error($sformatf("tag_checksum %h, expected %h", out_tag_checksum, e.cs));
        if (out_status !== e.st)
          note_error($sformatf("status %0d, expected %0d", out_status, e.st));
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Reset, directed table, random frames, drain
  initial begin
    int r;
    int dir_count;
    bit need_start;
    string s_all_f;
    string s_bad;
    clear_frame_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // all-F frame: largest data, checksum matches
    s_all_f = "FFFFFFFFFFFF";
    for (int i = 0; i < FRAME_CHARS; i++)
      add_row(s_all_f[i], i == 0, i == FRAME_CHARS - 1,
              tag_result_t'{40'hFF_FFFF_FFFF, 8'hFF, STATUS_OK});
    // lowercase digit and top code, then dropped by a restart
    add_row("a", 1'b1, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    // bad char on top of a checksum mismatch: bad char wins
    s_bad = "00000000001:";
    for (int i = 0; i < FRAME_CHARS; i++)
      add_row(s_bad[i], i == 0, i == FRAME_CHARS - 1,
              tag_result_t'{40'h0, 8'h10, STATUS_BAD_CHAR});

    foreach (dir_rows[i])
      send_char(dir_rows[i].ch, dir_rows[i].start, dir_rows[i].fixed, dir_rows[i].res);
    dir_count = chars_sent;

    hold_req = 1'b1;
    need_start = 1'b0;
    while (chars_sent < dir_count + RAND_CHARS) begin
      if (chars_sent > dir_count + RAND_CHARS - QUIET_CHARS) quiet = 1'b1;
      r = $urandom_range(99);
      if (r < 60) begin
        send_frame(FR_GOOD, need_start);
        need_start = 1'b0;
      end else if (r < 75) begin
        send_frame(FR_MISMATCH, need_start);
        need_start = 1'b0;
      end else if (r < 87) begin
        send_frame(FR_BADCHAR, need_start);
        need_start = 1'b0;
      end else begin
        send_noise();
        need_start = 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (expected_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters, %0d frames decoded: %0d ok, %0d checksum mismatch,",
             chars_sent, frames_seen, n_ok, n_mismatch);
    $display("%0d with bad characters; %0d mismatches found", n_bad, errors);
    if (errors == 0 && expected_tags.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rfid_hex_pkg.sv
rtl/rfid_hex_front.sv
rtl/rfid_hex_queue.sv
rtl/rfid_hex_back.sv
rtl/rfid_hex_tag_decode_check_top.sv
dv/rfid_hex_tag_decode_check_top_tb.sv
